FILE: design/lcgrd_pkg.sv
// lcgrd_pkg: shared constants, microcode types, control store and dispatch table
// for the 48-bit LCG random draw unit. No dependencies.
package lcgrd_pkg;

  localparam int STATE_W = 48;
  localparam int MULT_W  = 35;
  localparam int VALUE_W = 53;
  localparam int BOUND_W = 31;
  localparam int PC_W    = 5;

  localparam logic [MULT_W-1:0]  LCG_MULT  = 35'h5DEECE66D;
  localparam logic [STATE_W-1:0] LCG_INC   = 48'd11;
  localparam logic [5:0]         MULT_LAST = 6'd34;
  localparam logic [4:0]         REM_LAST  = 5'd30;

  // action codes
  localparam logic [2:0] ACT_SEED  = 3'd0;
  localparam logic [2:0] ACT_RAW   = 3'd1;
  localparam logic [2:0] ACT_INT32 = 3'd2;
  localparam logic [2:0] ACT_BELOW = 3'd3;
  localparam logic [2:0] ACT_FRAC  = 3'd4;
  localparam logic [2:0] ACT_BOOL  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED,
    OP_ADV_GO,
    OP_TAKE_RAW,
    OP_TAKE_32,
    OP_TAKE_1,
    OP_TAKE_A26,
    OP_FRAC,
    OP_TAKE_R31,
    OP_MUL,
    OP_POW2,
    OP_REM_GO,
    OP_TAKE_REM,
    OP_CLEAR,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_LCG_BUSY,
    COND_REM_BUSY,
    COND_POW2,
    COND_REJECT
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic lcg_busy;
    logic rem_busy;
    logic pow2;
    logic reject;
  } cond_flags_t;

  // control store addresses
  localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] A_SEED  = 5'd1;
  localparam logic [PC_W-1:0] A_RAW   = 5'd2;
  localparam logic [PC_W-1:0] A_INT32 = 5'd5;
  localparam logic [PC_W-1:0] A_BOOL  = 5'd8;
  localparam logic [PC_W-1:0] A_FRAC  = 5'd11;
  localparam logic [PC_W-1:0] A_BELOW = 5'd17;
  localparam logic [PC_W-1:0] A_DONE  = 5'd23;
  localparam logic [PC_W-1:0] A_PWR2  = 5'd24;
  localparam logic [PC_W-1:0] A_NOP   = 5'd26;

  function automatic logic [PC_W-1:0] dispatch(input logic [2:0] action);
    logic [PC_W-1:0] a;
    unique case (action)
      ACT_SEED:  a = A_SEED;
      ACT_RAW:   a = A_RAW;
      ACT_INT32: a = A_INT32;
      ACT_BELOW: a = A_BELOW;
      ACT_FRAC:  a = A_FRAC;
      ACT_BOOL:  a = A_BOOL;
      default:   a = A_NOP;
    endcase
    return a;
  endfunction

  function automatic ctrl_word_t rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      5'd0:  w = '{op: OP_NONE,     cond: COND_START,    target: A_IDLE};
      5'd1:  w = '{op: OP_SEED,     cond: COND_ALWAYS,   target: A_DONE};
      5'd2:  w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd3};
      5'd3:  w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd3};
      5'd4:  w = '{op: OP_TAKE_RAW, cond: COND_ALWAYS,   target: A_DONE};
      5'd5:  w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd6};
      5'd6:  w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd6};
      5'd7:  w = '{op: OP_TAKE_32,  cond: COND_ALWAYS,   target: A_DONE};
      5'd8:  w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd9};
      5'd9:  w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd9};
      5'd10: w = '{op: OP_TAKE_1,   cond: COND_ALWAYS,   target: A_DONE};
      5'd11: w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd12};
      5'd12: w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd12};
      5'd13: w = '{op: OP_TAKE_A26, cond: COND_ALWAYS,   target: 5'd14};
      5'd14: w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd15};
      5'd15: w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd15};
      5'd16: w = '{op: OP_FRAC,     cond: COND_ALWAYS,   target: A_DONE};
      5'd17: w = '{op: OP_ADV_GO,   cond: COND_ALWAYS,   target: 5'd18};
      5'd18: w = '{op: OP_NONE,     cond: COND_LCG_BUSY, target: 5'd18};
      5'd19: w = '{op: OP_TAKE_R31, cond: COND_ALWAYS,   target: 5'd20};
      5'd20: w = '{op: OP_REM_GO,   cond: COND_POW2,     target: A_PWR2};
      5'd21: w = '{op: OP_NONE,     cond: COND_REM_BUSY, target: 5'd21};
      5'd22: w = '{op: OP_TAKE_REM, cond: COND_REJECT,   target: A_BELOW};
      5'd23: w = '{op: OP_DONE,     cond: COND_ALWAYS,   target: A_IDLE};
      5'd24: w = '{op: OP_MUL,      cond: COND_ALWAYS,   target: 5'd25};
      5'd25: w = '{op: OP_POW2,     cond: COND_ALWAYS,   target: A_DONE};
      5'd26: w = '{op: OP_CLEAR,    cond: COND_ALWAYS,   target: A_DONE};
      default: w = '{op: OP_NONE,   cond: COND_ALWAYS,   target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/lcgrd_lcg.sv
// lcgrd_lcg: generator state and serial shift-add multiplier, one multiplier bit
// per cycle. Depends on lcgrd_pkg.
module lcgrd_lcg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seed_load,
  input  logic [lcgrd_pkg::STATE_W-1:0] seed_state,
  input  logic                          go,
  output logic                          busy,
  output logic [lcgrd_pkg::STATE_W-1:0] state
);

  logic [lcgrd_pkg::STATE_W-1:0] acc;
  logic [lcgrd_pkg::STATE_W-1:0] acc_next;
  logic [lcgrd_pkg::STATE_W-1:0] sh;
  logic [5:0]                    idx;

  assign acc_next = lcgrd_pkg::LCG_MULT[idx] ? acc + sh : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      state <= '0;
      idx   <= '0;
    end else begin
      if (seed_load) begin
        state <= seed_state;
      end
      if (go) begin
        busy <= 1'b1;
        acc  <= lcgrd_pkg::LCG_INC;
        sh   <= state;
        idx  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        sh  <= {sh[lcgrd_pkg::STATE_W-2:0], 1'b0};
        idx <= idx + 6'd1;
        if (idx == lcgrd_pkg::MULT_LAST) begin
          busy  <= 1'b0;
          state <= acc_next;
        end
      end
    end
  end

endmodule

FILE: design/lcgrd_rem.sv
// lcgrd_rem: 31-bit restoring remainder unit, one quotient bit per cycle.
// Depends on lcgrd_pkg.
module lcgrd_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [lcgrd_pkg::BOUND_W-1:0] num,
  input  logic [lcgrd_pkg::BOUND_W-1:0] den,
  output logic                          busy,
  output logic [lcgrd_pkg::BOUND_W-1:0] rem
);

  logic [lcgrd_pkg::BOUND_W-1:0] num_sh;
  logic [4:0]                    cnt;
  logic [lcgrd_pkg::BOUND_W:0]   part;
  logic [lcgrd_pkg::BOUND_W+1:0] diff;

  assign part = {rem, num_sh[lcgrd_pkg::BOUND_W-1]};
  assign diff = {1'b0, part} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy   <= 1'b1;
      rem    <= '0;
      num_sh <= num;
      cnt    <= '0;
    end else if (busy) begin
      rem    <= diff[lcgrd_pkg::BOUND_W+1] ? part[lcgrd_pkg::BOUND_W-1:0]
                                          : diff[lcgrd_pkg::BOUND_W-1:0];
      num_sh <= {num_sh[lcgrd_pkg::BOUND_W-2:0], 1'b0};
      cnt    <= cnt + 5'd1;
      if (cnt == lcgrd_pkg::REM_LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: design/lcgrd_seq.sv
// lcgrd_seq: microprogram counter, control store readout and branch logic.
// Depends on lcgrd_pkg (control store, dispatch table, word types).
module lcgrd_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2:0]               action,
  input  lcgrd_pkg::cond_flags_t   flags,
  output logic                     busy,
  output lcgrd_pkg::ctrl_word_t    cw
);

  logic [lcgrd_pkg::PC_W-1:0] pc;
  logic [lcgrd_pkg::PC_W-1:0] pc_next;
  logic                       taken;

  assign cw   = lcgrd_pkg::rom(pc);
  assign busy = (pc != lcgrd_pkg::A_IDLE);

  always_comb begin
    unique case (cw.cond)
      lcgrd_pkg::COND_ALWAYS:   taken = 1'b1;
      lcgrd_pkg::COND_START:    taken = 1'b0;
      lcgrd_pkg::COND_LCG_BUSY: taken = flags.lcg_busy;
      lcgrd_pkg::COND_REM_BUSY: taken = flags.rem_busy;
      lcgrd_pkg::COND_POW2:     taken = flags.pow2;
      lcgrd_pkg::COND_REJECT:   taken = flags.reject;
      default:                  taken = 1'b0;
    endcase
    if (cw.cond == lcgrd_pkg::COND_START) begin
      pc_next = start ? lcgrd_pkg::dispatch(action) : pc;
    end else if (taken) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lcgrd_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: design/lcg48_random_draw_unit_top.sv
// lcg48_random_draw_unit_top: 48-bit LCG random draw unit, datapath and glue.
// Depends on lcgrd_pkg, lcgrd_lcg, lcgrd_rem, lcgrd_seq.
//
//   channel  | handshake           | word
//   ---------+---------------------+-----------------------------------------
//   command  | start, busy         | action, seed_value, draw_bits, bound
//   result   | done (1-cycle)      | value
//
// A command is taken when start is high and busy is low; done pulses for one
// cycle with value, and busy drops the cycle after. One command at a time.
// A generator step is a launch, a serial multiply over the 35 multiplier bits,
// then a handoff. Seed and unused actions go straight to done; raw, int32 and
// boolean take a step, fraction a step per half. A bound takes a step, then a
// multiply if a power of two, else a remainder and check, retried on reject.
// Reset (rst, synchronous) clears the state to zero. The receiver cannot stall.
module lcg48_random_draw_unit_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action,
  input  logic signed [63:0]            seed_value,
  input  logic [5:0]                    draw_bits,
  input  logic [lcgrd_pkg::BOUND_W-1:0] bound,
  output logic                          done,
  output logic [lcgrd_pkg::VALUE_W-1:0] value
);

  lcgrd_pkg::ctrl_word_t         cw;
  lcgrd_pkg::cond_flags_t        flags;
  logic                          accept;
  logic [lcgrd_pkg::STATE_W-1:0] seed_state;
  logic [5:0]                    nb;
  logic [lcgrd_pkg::BOUND_W-1:0] n;
  logic [lcgrd_pkg::BOUND_W-1:0] r;
  logic [25:0]                   hi26;
  logic [lcgrd_pkg::BOUND_W-1:0] mul_hi;
  logic [61:0]                   prod;
  logic [lcgrd_pkg::STATE_W-1:0] state;
  logic [lcgrd_pkg::BOUND_W-1:0] rem;
  logic [31:0]                   raw_sh;
  logic [lcgrd_pkg::BOUND_W+1:0] chk;
  logic                          lcg_busy;
  logic                          rem_busy;

  assign accept = start & ~busy;
  assign done   = (cw.op == lcgrd_pkg::OP_DONE);
  assign prod   = {31'd0, n} * {31'd0, r};
  assign raw_sh = state[47:16] >> (6'd32 - nb);
  assign chk    = {2'b00, r} - {2'b00, rem} + {2'b00, n} - 33'd1;

  assign flags.lcg_busy = lcg_busy;
  assign flags.rem_busy = rem_busy;
  assign flags.pow2     = ((n & (~n + 31'd1)) == n);
  assign flags.reject   = (chk[32:31] != 2'b00);

  always_ff @(posedge clk) begin
    if (accept) begin
      seed_state <= seed_value[47:0] ^ {13'd0, lcgrd_pkg::LCG_MULT};
      n          <= bound;
      if (draw_bits == 6'd0) begin
        nb <= 6'd1;
      end else if (draw_bits > 6'd32) begin
        nb <= 6'd32;
      end else begin
        nb <= draw_bits;
      end
    end
    unique case (cw.op)
      lcgrd_pkg::OP_SEED:     value <= '0;
      lcgrd_pkg::OP_CLEAR:    value <= '0;
      lcgrd_pkg::OP_TAKE_RAW: value <= {21'd0, raw_sh};
      lcgrd_pkg::OP_TAKE_32:  value <= {21'd0, state[47:16]};
      lcgrd_pkg::OP_TAKE_1:   value <= {52'd0, state[47]};
      lcgrd_pkg::OP_TAKE_A26: hi26  <= state[47:22];
      lcgrd_pkg::OP_FRAC:     value <= {hi26, state[47:21]};
      lcgrd_pkg::OP_TAKE_R31: r     <= state[47:17];
      lcgrd_pkg::OP_MUL:      mul_hi <= prod[61:31];
      lcgrd_pkg::OP_POW2:     value <= {22'd0, mul_hi};
      lcgrd_pkg::OP_TAKE_REM: value <= {22'd0, rem};
      default: ;
    endcase
  end

  lcgrd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .flags  (flags),
    .busy   (busy),
    .cw     (cw)
  );

  lcgrd_lcg u_lcg (
    .clk        (clk),
    .rst        (rst),
    .seed_load  (cw.op == lcgrd_pkg::OP_SEED),
    .seed_state (seed_state),
    .go         (cw.op == lcgrd_pkg::OP_ADV_GO),
    .busy       (lcg_busy),
    .state      (state)
  );

  lcgrd_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .go   (cw.op == lcgrd_pkg::OP_REM_GO),
    .num  (r),
    .den  (n),
    .busy (rem_busy),
    .rem  (rem)
  );

endmodule
